// File: design/stpg_pkg.sv
// shared types, constants and codes of the stepper trapezoid pulse generator
package stpg_pkg;

    localparam int TickRateHz = 1000000;
    localparam int CountWidth = 32;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_ERROR    = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_STOPPED  = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;
    localparam logic [2:0] ST_MOVING   = 3'd6;

    localparam logic [1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_MIN_ACCEL = 2'd2;
    localparam logic [1:0] REG_MAX_ACCEL = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         axis_id;
        logic signed [31:0] move_steps;
        logic [15:0]        move_speed;
        logic [15:0]        move_accel;
        logic [15:0]        move_tag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  axis_echo;
        logic [15:0] tag_echo;
        logic [31:0] steps_done;
        logic        step_line;
        logic        dir_line;
        logic        moving;
        logic [15:0] speed_now;
    } out_item_t;

    // datapath operation selected by the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_EXEC,
        CMD_RAMP_DIV,
        CMD_RAMP_APPLY,
        CMD_PERIOD_DIV,
        CMD_PERIOD_APPLY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_ramp;
        logic need_period;
        logic div_busy;
    } dp_stat_t;

endpackage

// File: design/stepper_trapezoid_pulse_generator_unit.sv
// top level of the stepper trapezoid pulse generator
// One item at a time, one result per item. A tick without a ramp update, a stop, a query or a
// rejected or busy start runs no divide before its result is registered. An accepted start
// runs one 40-bit divide for the half period before its result is registered; a tick on a
// falling step edge that continues the move runs the braking and speed-step divides side by
// side, then the period divide, and only then has its result. The iterative divider works at
// one quotient bit per clock. The next item is taken only once the result has left the output
// register, so the unit never takes a new item before it is through with the last one.
module stepper_trapezoid_pulse_generator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  stpg_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output stpg_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import stpg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stpg_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    stpg_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_data)
    );
endmodule

// File: design/stpg_divider.sv
// iterative restoring divider, one quotient bit per cycle, all ones on zero divisor
module stpg_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [39:0] divisor,
    output logic        busy,
    output logic [39:0] quotient
);
    import stpg_pkg::*;

    logic [39:0] quo_reg, quo_next;
    logic [39:0] rem_reg, rem_next;
    logic [39:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [40:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[39]};
        if (start)
        begin
            if (divisor == 40'd0)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
            end
            else
            begin
                quo_next  = dividend;
                rem_next  = '0;
                dvs_next  = divisor;
                cnt_next  = 6'd40;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial[39:0] - dvs_reg;
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = trial[39:0];
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// File: design/stpg_datapath.sv
// motion state, item decode, ramp and period arithmetic
module stpg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  stpg_pkg::in_item_t in_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    input  stpg_pkg::dp_cmd_t  cmd,
    output stpg_pkg::dp_stat_t stat,
    output stpg_pkg::out_item_t out_item
);
    import stpg_pkg::*;

    localparam logic [39:0] TickRate = 40'(TickRateHz);
    localparam logic [CountWidth-1:0] CntMax = '1;

    logic [15:0] min_speed_reg, min_speed_next, max_speed_reg, max_speed_next;
    logic [15:0] min_accel_reg, min_accel_next, max_accel_reg, max_accel_next;
    logic        run_reg, run_next, pulse_reg, pulse_next, dir_reg, dir_next;
    logic [31:0] goal_steps_reg, goal_steps_next, step_cnt_reg, step_cnt_next;
    logic [15:0] goal_speed_reg, goal_speed_next, ramp_reg, ramp_next;
    logic [15:0] accel_reg, accel_next, tag_reg, tag_next;
    logic [CountWidth-1:0] reload_reg, reload_next, tick_reg, tick_next;
    logic [39:0] brake_reg, brake_next;
    logic [15:0] delta_reg, delta_next;
    logic        need_ramp_reg, need_ramp_next, need_period_reg, need_period_next;
    logic        delta_phase_reg, delta_phase_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  axis_echo_reg, axis_echo_next;
    logic [15:0] tag_echo_reg, tag_echo_next;
    logic [31:0] steps_done_reg, steps_done_next;

    logic        div_start;
    logic [39:0] div_a, div_b, div_q;
    logic        div_busy;
    logic        ddiv_start, ddiv_busy;
    logic [39:0] ddiv_q;
    logic [15:0] dq;
    logic [31:0] sq;

    logic        bad_start, axis_ok;
    logic [31:0] sraw, mag;
    logic [15:0] start_spd;
    logic [31:0] remaining;
    logic [16:0] up_sum, min_plus;
    logic [39:0] rl;

    stpg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // accel over ramp for the speed step, run beside the braking divide
    assign ddiv_start = (cmd.op == CMD_RAMP_DIV);

    stpg_divider u_ddiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ddiv_start),
        .dividend ({24'd0, accel_reg}),
        .divisor  ({24'd0, ramp_reg}),
        .busy     (ddiv_busy),
        .quotient (ddiv_q)
    );

    assign sq = 32'(ramp_reg) * 32'(ramp_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (cmd.op)
            CMD_RAMP_DIV:
            begin
                div_start = 1'b1;
                div_a     = 40'(sq);
                div_b     = {23'd0, accel_reg, 1'b0};
            end
            CMD_PERIOD_DIV:
            begin
                div_start = 1'b1;
                div_a     = TickRate;
                div_b     = {23'd0, ramp_reg, 1'b0};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        dq = (ramp_reg == 16'd0) ? 16'hFFFF : ddiv_q[15:0];
        if (dq == 16'd0)
            dq = 16'd1;
    end

    always_comb
    begin
        sraw      = in_item.move_steps;
        mag       = sraw[31] ? (32'd0 - sraw) : sraw;
        bad_start = (in_item.axis_id != 8'd0) || (sraw == 32'd0)
                 || (in_item.move_speed < min_speed_reg)
                 || (in_item.move_speed > max_speed_reg)
                 || (in_item.move_accel < min_accel_reg)
                 || (in_item.move_accel > max_accel_reg);
        start_spd = {2'b00, in_item.move_speed[15:2]};
        if (start_spd < min_speed_reg)
            start_spd = min_speed_reg;
        axis_ok   = (in_item.axis_id == 8'd0) || (in_item.axis_id == 8'hFF);
        remaining = goal_steps_reg - step_cnt_reg;
        up_sum    = {1'b0, ramp_reg} + {1'b0, delta_reg};
        min_plus  = {1'b0, min_speed_reg} + {1'b0, delta_reg};
        rl        = (div_q == 40'd0) ? 40'd0 : div_q - 40'd1;
        if (rl > 40'(CntMax))
            rl = 40'(CntMax);
    end

    always_comb
    begin
        min_speed_next   = min_speed_reg;
        max_speed_next   = max_speed_reg;
        min_accel_next   = min_accel_reg;
        max_accel_next   = max_accel_reg;
        run_next         = run_reg;
        pulse_next       = pulse_reg;
        dir_next         = dir_reg;
        goal_steps_next  = goal_steps_reg;
        step_cnt_next    = step_cnt_reg;
        goal_speed_next  = goal_speed_reg;
        ramp_next        = ramp_reg;
        accel_next       = accel_reg;
        tag_next         = tag_reg;
        reload_next      = reload_reg;
        tick_next        = tick_reg;
        brake_next       = brake_reg;
        delta_next       = delta_reg;
        need_ramp_next   = need_ramp_reg;
        need_period_next = need_period_reg;
        delta_phase_next = delta_phase_reg;
        status_next      = status_reg;
        axis_echo_next   = axis_echo_reg;
        tag_echo_next    = tag_echo_reg;
        steps_done_next  = steps_done_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_MIN_SPEED: min_speed_next = cfg_data;
                REG_MAX_SPEED: max_speed_next = cfg_data;
                REG_MIN_ACCEL: min_accel_next = cfg_data;
                REG_MAX_ACCEL: max_accel_next = cfg_data;
                default: ;
            endcase
        end
        case (cmd.op)
            CMD_EXEC:
            begin
                need_ramp_next   = 1'b0;
                need_period_next = 1'b0;
                status_next      = ST_NONE;
                axis_echo_next   = '0;
                tag_echo_next    = '0;
                steps_done_next  = '0;
                case (in_item.opcode)
                    OP_TICK:
                    begin
                        if (run_reg)
                        begin
                            if (tick_reg < reload_reg)
                                tick_next = tick_reg + CountWidth'(1);
                            else
                            begin
                                tick_next = '0;
                                if (pulse_reg)
                                begin
                                    pulse_next = 1'b0;
                                    if (step_cnt_reg >= goal_steps_reg)
                                    begin
                                        run_next        = 1'b0;
                                        status_next     = ST_DONE;
                                        tag_echo_next   = tag_reg;
                                        steps_done_next = step_cnt_reg;
                                    end
                                    else
                                        need_ramp_next = 1'b1;
                                end
                                else
                                begin
                                    pulse_next    = 1'b1;
                                    step_cnt_next = step_cnt_reg + 32'd1;
                                end
                            end
                        end
                    end
                    OP_START:
                    begin
                        axis_echo_next = in_item.axis_id;
                        tag_echo_next  = in_item.move_tag;
                        if (bad_start)
                            status_next = ST_ERROR;
                        else if (run_reg)
                        begin
                            status_next     = ST_BUSY;
                            steps_done_next = step_cnt_reg;
                        end
                        else
                        begin
                            status_next      = ST_ACCEPTED;
                            dir_next         = ~sraw[31];
                            goal_steps_next  = mag;
                            step_cnt_next    = '0;
                            goal_speed_next  = in_item.move_speed;
                            ramp_next        = start_spd;
                            accel_next       = in_item.move_accel;
                            tag_next         = in_item.move_tag;
                            pulse_next       = 1'b0;
                            run_next         = 1'b1;
                            tick_next        = '0;
                            need_period_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!axis_ok)
                        begin
                            status_next    = ST_ERROR;
                            axis_echo_next = in_item.axis_id;
                        end
                        else
                        begin
                            tag_echo_next   = tag_reg;
                            steps_done_next = step_cnt_reg;
                            if (in_item.opcode == OP_STOP)
                            begin
                                status_next = ST_STOPPED;
                                run_next    = 1'b0;
                                pulse_next  = 1'b0;
                            end
                            else
                                status_next = run_reg ? ST_MOVING : ST_DONE;
                        end
                    end
                endcase
            end
            CMD_RAMP_DIV:
                delta_phase_next = 1'b0;
            CMD_RAMP_APPLY:
            begin
                if (!delta_phase_reg)
                begin
                    // first pass captures the braking distance and the speed step
                    brake_next       = div_q;
                    delta_next       = dq;
                    delta_phase_next = 1'b1;
                end
                else
                begin
                    delta_phase_next = 1'b0;
                    need_ramp_next   = 1'b0;
                    need_period_next = 1'b1;
                    if ((40'(remaining) <= brake_reg) && (ramp_reg > min_speed_reg))
                        ramp_next = ({1'b0, ramp_reg} > min_plus)
                                    ? ramp_reg - delta_reg : min_speed_reg;
                    else if (ramp_reg < goal_speed_reg)
                        ramp_next = (up_sum < {1'b0, goal_speed_reg})
                                    ? up_sum[15:0] : goal_speed_reg;
                end
            end
            CMD_PERIOD_APPLY:
            begin
                need_period_next = 1'b0;
                reload_next      = rl[CountWidth-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg   <= 16'd100;
            max_speed_reg   <= 16'd40000;
            min_accel_reg   <= 16'd100;
            max_accel_reg   <= 16'd20000;
            run_reg         <= 1'b0;
            pulse_reg       <= 1'b0;
            dir_reg         <= 1'b1;
            goal_steps_reg  <= '0;
            step_cnt_reg    <= '0;
            goal_speed_reg  <= '0;
            ramp_reg        <= '0;
            accel_reg       <= '0;
            tag_reg         <= '0;
            reload_reg      <= '0;
            tick_reg        <= '0;
            brake_reg       <= '0;
            delta_reg       <= '0;
            need_ramp_reg   <= 1'b0;
            need_period_reg <= 1'b0;
            delta_phase_reg <= 1'b0;
            status_reg      <= ST_NONE;
            axis_echo_reg   <= '0;
            tag_echo_reg    <= '0;
            steps_done_reg  <= '0;
        end
        else
        begin
            min_speed_reg   <= min_speed_next;
            max_speed_reg   <= max_speed_next;
            min_accel_reg   <= min_accel_next;
            max_accel_reg   <= max_accel_next;
            run_reg         <= run_next;
            pulse_reg       <= pulse_next;
            dir_reg         <= dir_next;
            goal_steps_reg  <= goal_steps_next;
            step_cnt_reg    <= step_cnt_next;
            goal_speed_reg  <= goal_speed_next;
            ramp_reg        <= ramp_next;
            accel_reg       <= accel_next;
            tag_reg         <= tag_next;
            reload_reg      <= reload_next;
            tick_reg        <= tick_next;
            brake_reg       <= brake_next;
            delta_reg       <= delta_next;
            need_ramp_reg   <= need_ramp_next;
            need_period_reg <= need_period_next;
            delta_phase_reg <= delta_phase_next;
            status_reg      <= status_next;
            axis_echo_reg   <= axis_echo_next;
            tag_echo_reg    <= tag_echo_next;
            steps_done_reg  <= steps_done_next;
        end
    end

    assign stat.need_ramp      = need_ramp_reg;
    assign stat.need_period    = need_period_reg;
    assign stat.div_busy       = div_busy | ddiv_busy;
    assign out_item.status     = status_reg;
    assign out_item.axis_echo  = axis_echo_reg;
    assign out_item.tag_echo   = tag_echo_reg;
    assign out_item.steps_done = steps_done_reg;
    assign out_item.step_line  = pulse_reg;
    assign out_item.dir_line   = dir_reg;
    assign out_item.moving     = run_reg;
    assign out_item.speed_now  = ramp_reg;
endmodule

// File: design/stpg_control.sv
// sequencer for item execution, ramp update and period reload
module stpg_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  stpg_pkg::dp_stat_t stat,
    output stpg_pkg::dp_cmd_t  cmd
);
    import stpg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RAMP_WAIT,
        S_RAMP_APPLY,
        S_PER_WAIT,
        S_SYNC,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.op = CMD_NONE;
        case (state_reg)
            S_IDLE:       cmd.op = (in_valid && !out_valid_reg) ? CMD_EXEC : CMD_NONE;
            S_EXEC:
            begin
                if (stat.need_ramp)
                    cmd.op = CMD_RAMP_DIV;
                else if (stat.need_period)
                    cmd.op = CMD_PERIOD_DIV;
            end
            S_RAMP_WAIT:  cmd.op = stat.div_busy ? CMD_NONE : CMD_RAMP_APPLY;
            S_RAMP_APPLY: cmd.op = CMD_RAMP_APPLY;
            S_PER_WAIT:   cmd.op = stat.div_busy ? CMD_NONE : CMD_PERIOD_APPLY;
            default:      cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (cmd.op == CMD_EXEC)
                        state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (stat.need_ramp)
                        state_reg <= S_RAMP_WAIT;
                    else if (stat.need_period)
                        state_reg <= S_PER_WAIT;
                    else
                        state_reg <= S_SYNC;
                end
                S_RAMP_WAIT:
                    if (!stat.div_busy)
                        state_reg <= S_RAMP_APPLY;
                S_RAMP_APPLY:
                    state_reg <= S_EXEC;
                S_PER_WAIT:
                    if (!stat.div_busy)
                        state_reg <= S_SYNC;
                S_SYNC:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
endmodule
